// ===== rtl/core/msd_pkg.sv =====
// Shared types, character codes and the code lookup table of the Morse symbol decoder.
`timescale 1ns / 1ps

package msd_pkg;

  // Input characters with a meaning of their own.
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Glyph sent for a completed word gap.
  localparam logic [6:0] GLYPH_SPACE = 7'h20;

  // Longest code, and the saturated length that marks an overlong symbol.
  localparam logic [2:0] MAX_CODE_LEN = 3'd5;
  localparam logic [2:0] OVERLONG_LEN = 3'd6;

  // Result buffer geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [4:0] pattern;
    logic [2:0] length;
    logic [1:0] space_run;
    logic       any_matched;
    logic       discarding;
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] character;
    logic       last;
  } result_t;

  // Element k of a symbol sits in pattern bit k, a dash is a one.
  // Returns the ASCII glyph, or zero when the symbol matches no code.
  function automatic logic [6:0] lookup_glyph(input logic [2:0] len,
                                              input logic [4:0] pat);
    logic [6:0] glyph;
    glyph = 7'd0;
    unique case ({len, pat})
      {3'd2, 5'd2}:  glyph = 7'h41; // A
      {3'd4, 5'd1}:  glyph = 7'h42; // B
      {3'd4, 5'd5}:  glyph = 7'h43; // C
      {3'd3, 5'd1}:  glyph = 7'h44; // D
      {3'd1, 5'd0}:  glyph = 7'h45; // E
      {3'd4, 5'd4}:  glyph = 7'h46; // F
      {3'd3, 5'd3}:  glyph = 7'h47; // G
      {3'd4, 5'd0}:  glyph = 7'h48; // H
      {3'd2, 5'd0}:  glyph = 7'h49; // I
      {3'd4, 5'd14}: glyph = 7'h4A; // J
      {3'd3, 5'd5}:  glyph = 7'h4B; // K
      {3'd4, 5'd2}:  glyph = 7'h4C; // L
      {3'd2, 5'd3}:  glyph = 7'h4D; // M
      {3'd2, 5'd1}:  glyph = 7'h4E; // N
      {3'd3, 5'd7}:  glyph = 7'h4F; // O
      {3'd4, 5'd6}:  glyph = 7'h50; // P
      {3'd4, 5'd11}: glyph = 7'h51; // Q
      {3'd3, 5'd2}:  glyph = 7'h52; // R
      {3'd3, 5'd0}:  glyph = 7'h53; // S
      {3'd1, 5'd1}:  glyph = 7'h54; // T
      {3'd3, 5'd4}:  glyph = 7'h55; // U
      {3'd4, 5'd8}:  glyph = 7'h56; // V
      {3'd3, 5'd6}:  glyph = 7'h57; // W
      {3'd4, 5'd9}:  glyph = 7'h58; // X
      {3'd4, 5'd13}: glyph = 7'h59; // Y
      {3'd4, 5'd3}:  glyph = 7'h5A; // Z
      {3'd5, 5'd30}: glyph = 7'h31; // 1
      {3'd5, 5'd28}: glyph = 7'h32; // 2
      {3'd5, 5'd24}: glyph = 7'h33; // 3
      {3'd5, 5'd16}: glyph = 7'h34; // 4
      {3'd5, 5'd0}:  glyph = 7'h35; // 5
      {3'd5, 5'd1}:  glyph = 7'h36; // 6
      {3'd5, 5'd3}:  glyph = 7'h37; // 7
      {3'd5, 5'd7}:  glyph = 7'h38; // 8
      {3'd5, 5'd15}: glyph = 7'h39; // 9
      {3'd5, 5'd31}: glyph = 7'h30; // 0
      default:       glyph = 7'd0;
    endcase
    return glyph;
  endfunction

endpackage

// ===== rtl/core/msd_ifs.sv =====
// Valid/ready channel interfaces for input characters and decoded results.
`timescale 1ns / 1ps

interface msd_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface msd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output kind, output character, output last, input ready);
  modport sink   (input valid, input kind, input character, input last, output ready);
endinterface

// ===== rtl/core/msd_step.sv =====
// Next-state and result logic for one input character of the Morse decoder.
`timescale 1ns / 1ps

module msd_step (
  input  logic [7:0]       symbol,
  input  msd_pkg::state_t  cur,
  output msd_pkg::state_t  nxt,
  output logic [1:0]       push_n,
  output msd_pkg::result_t r0,
  output msd_pkg::result_t r1
);

  logic             is_elem;
  logic             is_gap;
  logic [6:0]       glyph;
  logic             hit;
  logic             first_v;
  logic             second_v;
  msd_pkg::result_t first;
  msd_pkg::result_t second;

  assign is_elem = (symbol == msd_pkg::CHAR_DOT) || (symbol == msd_pkg::CHAR_DASH);
  assign is_gap  = (symbol == msd_pkg::CHAR_SPACE);

  // Lengths of zero and six have no table entry, so they never match.
  assign glyph = msd_pkg::lookup_glyph(cur.length, cur.pattern);
  assign hit   = (glyph != 7'd0);

  always_comb begin
    nxt      = cur;
    first_v  = 1'b0;
    first    = '{kind: msd_pkg::KIND_CHAR, character: glyph, last: 1'b0};
    second_v = 1'b0;
    second   = '{kind: msd_pkg::KIND_CHAR, character: msd_pkg::GLYPH_SPACE, last: 1'b0};

    if (cur.discarding) begin
      if (!is_elem && !is_gap) begin
        nxt = '0;
      end
    end else if (is_elem) begin
      if (cur.space_run[1]) begin
        // A bad space run ended by an element fails the message at once.
        first_v        = 1'b1;
        first          = '{kind: msd_pkg::KIND_FAIL, character: 7'd0, last: 1'b1};
        nxt            = '0;
        nxt.discarding = 1'b1;
      end else begin
        nxt.space_run = 2'd0;
        if (cur.length < msd_pkg::MAX_CODE_LEN) begin
          if (symbol == msd_pkg::CHAR_DASH) begin
            nxt.pattern = cur.pattern | (5'd1 << cur.length);
          end
          nxt.length = cur.length + 3'd1;
        end else begin
          nxt.length = msd_pkg::OVERLONG_LEN;
        end
      end
    end else if (is_gap) begin
      first_v   = hit;
      if (hit) begin
        nxt.any_matched = 1'b1;
      end
      nxt.pattern   = 5'd0;
      nxt.length    = 3'd0;
      nxt.space_run = cur.space_run + 2'd1;
      second_v      = (cur.space_run == 2'd3);
    end else begin
      first_v  = hit;
      second_v = 1'b1;
      second   = '{kind: (cur.space_run[1] || !(cur.any_matched || hit)) ?
                         msd_pkg::KIND_FAIL : msd_pkg::KIND_OK,
                   character: 7'd0, last: 1'b1};
      nxt      = '0;
    end
  end

  assign r0     = first_v ? first : second;
  assign r1     = second;
  assign push_n = {1'b0, first_v} + {1'b0, second_v};

endmodule

// ===== rtl/core/msd_res_fifo.sv =====
// Small result buffer that takes up to two results per cycle and hands out one to a ready sink.
`timescale 1ns / 1ps

module msd_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  msd_pkg::result_t r0,
  input  msd_pkg::result_t r1,
  output logic             room,
  msd_res_if.source        results
);

  msd_pkg::result_t                mem [msd_pkg::FIFO_DEPTH];
  logic [msd_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [msd_pkg::FIFO_AW-1:0]     rd_ptr;
  logic [msd_pkg::FIFO_CW-1:0]     count;
  logic [msd_pkg::FIFO_CW-1:0]     count_next;
  logic                            pop;
  msd_pkg::result_t                head;

  assign head              = mem[rd_ptr];
  assign results.valid     = (count != '0);
  assign results.kind      = head.kind;
  assign results.character = head.character;
  assign results.last      = head.last;

  assign pop  = results.valid && results.ready;
  // Room for a full pair of results, whatever the sink does this cycle.
  assign room = (count <= msd_pkg::FIFO_CW'(msd_pkg::FIFO_DEPTH - 2));

  assign count_next = count + msd_pkg::FIFO_CW'(push_n)
                      - msd_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + msd_pkg::FIFO_AW'(push_n);
      rd_ptr <= rd_ptr + msd_pkg::FIFO_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= r0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + msd_pkg::FIFO_AW'(1)] <= r1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= msd_pkg::FIFO_CW'(msd_pkg::FIFO_DEPTH))
    else $error("result buffer count exceeds its depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> room)
    else $error("results written without room for a pair");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push_n == 2'd0) |=> count == $past(count) - msd_pkg::FIFO_CW'(1))
    else $error("result buffer count did not drop on a lone read");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty result buffer with unequal pointers");

endmodule

// ===== rtl/core/morse_symbol_decoder_core.sv =====
// Top level of the Morse symbol decoder: state register, step logic and result buffer.
`timescale 1ns / 1ps

// Usage:
// The symbols channel carries one ASCII character per transaction: '.' and '-'
// build up a symbol, ' ' closes it, and any other character ends the message.
// The results channel carries one result per transaction: a decoded letter,
// digit or word space (kind 0), or a message end (kind 1 success, kind 2
// failure, last high). One character can yield up to two results.
// Timing: when the result buffer is empty, a character accepted at a clock edge
// has its first result presented on the results channel right after that edge.
// Throughput: one character per cycle while each character yields at most one
// result and the receiver takes one result per cycle. A character that yields
// two results presents them one after the other, and the four-entry result
// buffer absorbs the extra result before backpressure reaches the input.
// Stall: the input stays ready while the result buffer has room for two more
// results, so a stalled receiver stops input once more than two results wait.
// Reset: rst is synchronous; it clears the symbol state, the message flags and
// the result buffer, and the block is ready in the first cycle after.
module morse_symbol_decoder_core (
  input  logic      clk,
  input  logic      rst,
  msd_sym_if.sink   symbols,
  msd_res_if.source results
);

  // Decoder state: the symbol being built, the current space run and the
  // per-message flags. It advances once per accepted character.
  msd_pkg::state_t  state;
  msd_pkg::state_t  state_next;
  logic [1:0]       step_push_n;
  logic [1:0]       push_n;
  msd_pkg::result_t r0;
  msd_pkg::result_t r1;
  logic             room;
  logic             accept;

  assign symbols.ready = room;
  assign accept        = symbols.valid && symbols.ready;

  // All per-character work is a table lookup and a few compares.
  msd_step u_step (
    .symbol (symbols.symbol),
    .cur    (state),
    .nxt    (state_next),
    .push_n (step_push_n),
    .r0     (r0),
    .r1     (r1)
  );

  // Results are written only for an accepted transaction.
  assign push_n = accept ? step_push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // The result buffer decouples the receiver from the input side.
  msd_res_fifo u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_n  (push_n),
    .r0      (r0),
    .r1      (r1),
    .room    (room),
    .results (results)
  );

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    state.discarding |-> (push_n == 2'd0))
    else $error("results written while discarding a failed message");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.last) |-> (results.kind != msd_pkg::KIND_CHAR))
    else $error("a decoded character closed the message");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (r0.kind == msd_pkg::KIND_CHAR && !r0.last))
    else $error("first of a result pair is not a plain character");

  a_overlong_empty: assert property (@(posedge clk) disable iff (rst)
    (state.length == msd_pkg::OVERLONG_LEN) |-> (state.space_run == 2'd0))
    else $error("overlong symbol with a pending space run");

endmodule
